// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 5;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CMPW    = ((CW > POS_W) ? CW : POS_W) + 1;

    // Removed value reported when nothing was taken out.
    localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_AT    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

// ===== rtl/pls_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_req_if
// Command channel of the positional list store.
// ----------------------------------------------------------------------------
interface pls_req_if;
    logic                              valid;
    logic                              ready;
    logic [pls_pkg::CMD_W-1:0]         cmd;
    logic [pls_pkg::POS_W-1:0]         position;
    logic signed [pls_pkg::DATA_W-1:0] new_value;

    modport source (output valid, output cmd, output position, output new_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input new_value,
                    output ready);
endinterface

// ===== rtl/pls_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_rsp_if
// Result channel of the positional list store.
// ----------------------------------------------------------------------------
interface pls_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [pls_pkg::DATA_W-1:0] removed_value;
    logic [1:0]                        status;
    logic [pls_pkg::LEN_W-1:0]         length;

    modport source (output valid, output removed_value, output status,
                    output length, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input length, output ready);
endinterface

// ===== rtl/positional_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of signed words with insert and remove at front, back or a
// 1-based position, kept in a RAM and moved one entry at a time.
// ----------------------------------------------------------------------------
// Steps: an error or an unused command goes straight to S_FINISH; an append
// writes its entry; an insert first moves the k entries behind the target up
// one by one; a delete reads the target, then moves the k entries behind it down.
// One item at a time: a new command is taken only once the last result has
// gone to the output register. Reset empties the list at once.
// ----------------------------------------------------------------------------
module positional_list_store_core (
    input  logic       clk,
    input  logic       rst_n,
    pls_req_if.sink    req,
    pls_rsp_if.source  rsp
);

    // The sequencer walks a cursor through the RAM. Inserts move entries up
    // from the back towards the target index; deletes read the target, then
    // move the entries behind it down by one.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DEL_RD,
        S_DEL_TAKE,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [pls_pkg::CW-1:0]              count_reg, count_next;
    logic [pls_pkg::AW-1:0]              idx_reg, idx_next;
    logic [pls_pkg::AW-1:0]              cur_reg, cur_next;
    logic signed [pls_pkg::DATA_W-1:0]   val_reg, val_next;
    logic signed [pls_pkg::DATA_W-1:0]   removed_reg, removed_next;
    pls_pkg::status_t                    status_reg, status_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [pls_pkg::DATA_W-1:0]   out_removed_reg, out_removed_next;
    logic [1:0]                          out_status_reg, out_status_next;
    logic [pls_pkg::LEN_W-1:0]           out_len_reg, out_len_next;

    // RAM port signals.
    logic                        ram_we;
    logic [pls_pkg::AW-1:0]      ram_waddr;
    logic [pls_pkg::DATA_W-1:0]  ram_wdata;
    logic [pls_pkg::AW-1:0]      ram_raddr;
    logic [pls_pkg::DATA_W-1:0]  ram_rdata;

    // Command checks, evaluated on the item as it is accepted.
    logic [pls_pkg::CMPW-1:0]    pos_ext;
    logic [pls_pkg::CMPW-1:0]    cnt_ext;
    logic                        is_full;
    logic                        is_empty;
    logic                        ins_pos_ok;
    logic                        del_pos_ok;
    logic [pls_pkg::AW-1:0]      pos_idx;
    logic [pls_pkg::AW-1:0]      cnt_idx;

    assign pos_ext    = pls_pkg::CMPW'(req.position);
    assign cnt_ext    = pls_pkg::CMPW'(count_reg);
    assign is_full    = (count_reg == pls_pkg::CW'(pls_pkg::DEPTH));
    assign is_empty   = (count_reg == '0);
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + pls_pkg::CMPW'(1));
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_idx    = pls_pkg::AW'(pos_ext - pls_pkg::CMPW'(1));
    assign cnt_idx    = count_reg[pls_pkg::AW-1:0];

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.length        = out_len_reg;

    pls_ram #(
        .WIDTH (pls_pkg::DATA_W),
        .DEPTH (pls_pkg::DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        val_next         = val_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_removed_next = out_removed_reg;
        out_status_next  = out_status_reg;
        out_len_next     = out_len_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = val_reg;
        ram_raddr        = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next     = req.new_value;
                    removed_next = pls_pkg::NONE_VALUE;
                    status_next  = pls_pkg::ST_OK;
                    state_next   = S_FINISH;
                    case (req.cmd)
                        pls_pkg::CMD_INS_FIRST,
                        pls_pkg::CMD_INS_LAST,
                        pls_pkg::CMD_INS_AT:
                        begin
                            if (is_full)
                            begin
                                status_next = pls_pkg::ST_FULL;
                            end
                            else if (req.cmd == pls_pkg::CMD_INS_AT && !ins_pos_ok)
                            begin
                                status_next = pls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                if (req.cmd == pls_pkg::CMD_INS_FIRST)
                                begin
                                    idx_next = '0;
                                end
                                else if (req.cmd == pls_pkg::CMD_INS_LAST)
                                begin
                                    idx_next = cnt_idx;
                                end
                                else
                                begin
                                    idx_next = pos_idx;
                                end
                                // Appending needs no move; otherwise start at
                                // the last entry and walk towards the front.
                                if (idx_next == cnt_idx)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    cur_next   = cnt_idx - pls_pkg::AW'(1);
                                    state_next = S_UP_RD;
                                end
                            end
                        end
                        pls_pkg::CMD_DEL_FIRST,
                        pls_pkg::CMD_DEL_LAST,
                        pls_pkg::CMD_DEL_AT:
                        begin
                            if (is_empty)
                            begin
                                status_next = pls_pkg::ST_EMPTY;
                            end
                            else if (req.cmd == pls_pkg::CMD_DEL_AT && !del_pos_ok)
                            begin
                                status_next = pls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                if (req.cmd == pls_pkg::CMD_DEL_FIRST)
                                begin
                                    idx_next = '0;
                                end
                                else if (req.cmd == pls_pkg::CMD_DEL_LAST)
                                begin
                                    idx_next = cnt_idx - pls_pkg::AW'(1);
                                end
                                else
                                begin
                                    idx_next = pos_idx;
                                end
                                state_next = S_DEL_RD;
                            end
                        end
                        default:
                        begin
                            // Unused codes leave the list alone and report ok.
                            status_next = pls_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                ram_raddr  = cur_reg;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg + pls_pkg::AW'(1);
                ram_wdata = ram_rdata;
                if (cur_reg == idx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cur_next   = cur_reg - pls_pkg::AW'(1);
                    state_next = S_UP_RD;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + pls_pkg::CW'(1);
                state_next = S_FINISH;
            end
            S_DEL_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_DEL_TAKE;
            end
            S_DEL_TAKE:
            begin
                removed_next = ram_rdata;
                if (pls_pkg::CW'(idx_reg) + pls_pkg::CW'(1) == count_reg)
                begin
                    count_next = count_reg - pls_pkg::CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next   = idx_reg + pls_pkg::AW'(1);
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                ram_raddr  = cur_reg;
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg - pls_pkg::AW'(1);
                ram_wdata = ram_rdata;
                if (pls_pkg::CW'(cur_reg) + pls_pkg::CW'(1) == count_reg)
                begin
                    count_next = count_reg - pls_pkg::CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next   = cur_reg + pls_pkg::AW'(1);
                    state_next = S_DN_RD;
                end
            end
            S_FINISH:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_removed_next = removed_reg;
                    out_status_next  = status_reg;
                    out_len_next     = pls_pkg::LEN_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            cur_reg         <= '0;
            val_reg         <= '0;
            removed_reg     <= '0;
            status_reg      <= pls_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_removed_reg <= '0;
            out_status_reg  <= '0;
            out_len_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            cur_reg         <= cur_next;
            val_reg         <= val_next;
            removed_reg     <= removed_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            out_removed_reg <= out_removed_next;
            out_status_reg  <= out_status_next;
            out_len_reg     <= out_len_next;
        end
    end

endmodule

// ===== rtl/pls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/tb_positional_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store_core
// Self-checking bench for the positional list store. A small tracker class
// keeps its own copy of the list. For each command item that the block takes,
// it works out the expected result item. Each result item is then checked
// field by field against the oldest prediction. A short directed
// sequence comes first. It is followed by randomized phases that grow,
// shrink or churn the list. Both channels idle at random, with bursts
// in between.
// ----------------------------------------------------------------------------
module tb_positional_list_store_core;

    // The command field is 3 bits wide, so two codes have no operation.
    localparam logic [pls_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [pls_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    // This window covers the slowest command.
    localparam int DRAIN_CYCLES = 2 * pls_pkg::DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_CHURN
    } phase_t;

    typedef struct packed {
        logic signed [pls_pkg::DATA_W-1:0] removed_value;
        pls_pkg::status_t                  status;
        logic [pls_pkg::LEN_W-1:0]         length;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Tracker: holds the expected list contents and the queue of predicted
    // result items. It counts every mismatch that it reports.
    // ------------------------------------------------------------------------
    class list_tracker;
        logic signed [pls_pkg::DATA_W-1:0] contents[$];
        list_result_t                      pending_results[$];
        int                                mismatches = 0;

        function int fill_level();
            return contents.size();
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        // Applies one accepted command item to the list and queues its result.
        function void note_command(logic [pls_pkg::CMD_W-1:0] code,
                                   logic [pls_pkg::POS_W-1:0] pos,
                                   logic signed [pls_pkg::DATA_W-1:0] value);
            list_result_t r;
            r.removed_value = pls_pkg::NONE_VALUE;
            r.status        = pls_pkg::ST_OK;
            case (code)
                pls_pkg::CMD_INS_FIRST, pls_pkg::CMD_INS_LAST, pls_pkg::CMD_INS_AT:
                begin
                    // Full takes priority over a bad position.
                    if (contents.size() >= pls_pkg::DEPTH)
                        r.status = pls_pkg::ST_FULL;
                    else if (code == pls_pkg::CMD_INS_FIRST)
                        contents.push_front(value);
                    else if (code == pls_pkg::CMD_INS_LAST)
                        contents.push_back(value);
                    else if (pos < 1 || pos > contents.size() + 1)
                        r.status = pls_pkg::ST_RANGE;
                    else
                        contents.insert(pos - 1, value);
                end
                pls_pkg::CMD_DEL_FIRST, pls_pkg::CMD_DEL_LAST, pls_pkg::CMD_DEL_AT:
                begin
                    if (contents.size() == 0)
                        r.status = pls_pkg::ST_EMPTY;
                    else if (code == pls_pkg::CMD_DEL_FIRST)
                        r.removed_value = contents.pop_front();
                    else if (code == pls_pkg::CMD_DEL_LAST)
                        r.removed_value = contents.pop_back();
                    else if (pos < 1 || pos > contents.size())
                        r.status = pls_pkg::ST_RANGE;
                    else
                    begin
                        r.removed_value = contents[pos - 1];
                        contents.delete(pos - 1);
                    end
                end
                default:
                    ;
            endcase
            r.length = pls_pkg::LEN_W'(contents.size());
            pending_results.push_back(r);
        endfunction

        task check_result(logic signed [pls_pkg::DATA_W-1:0] removed_value,
                          logic [1:0] status, logic [pls_pkg::LEN_W-1:0] length);
            list_result_t exp;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result item arrived with no prediction waiting");
                return;
            end
            exp = pending_results.pop_front();
            if (removed_value !== exp.removed_value)
                report_mismatch($sformatf("removed_value got %0d expected %0d",
                                          removed_value, exp.removed_value));
            if (status !== exp.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          status, exp.status));
            if (length !== exp.length)
                report_mismatch($sformatf("length got %0d expected %0d",
                                          length, exp.length));
        endtask

        task flag_leftovers();
            if (pending_results.size() != 0)
                report_mismatch($sformatf("%0d predicted result items never arrived",
                                          pending_results.size()));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    list_tracker tracker = new();

    // The sender's idle switch is flipped by the stimulus phases.
    bit send_idle_on = 1'b1;

    positional_list_store_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side. Valid is only lowered when a gap follows. So a
    // back-to-back item keeps valid high with a single assignment in that
    // time step. The caller is always at a rising edge on entry.
    // ------------------------------------------------------------------------
    task issue_command(logic [pls_pkg::CMD_W-1:0] code, logic [pls_pkg::POS_W-1:0] pos,
                       logic signed [pls_pkg::DATA_W-1:0] value);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= code;
        req_ch.position  <= pos;
        req_ch.new_value <= value;
        // Ready is sampled as it stood at the edge, before any update there.
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_command(code, pos, value);
    endtask

    // Draws one command item that fits the current phase. Most positions
    // fall in the legal window for the current length. The rest span the
    // whole 5-bit field, so the range errors get plenty of hits.
    task draw_command(phase_t phase, output logic [pls_pkg::CMD_W-1:0] code,
                      output logic [pls_pkg::POS_W-1:0] pos,
                      output logic signed [pls_pkg::DATA_W-1:0] value);
        int roll;
        int len;
        int insert_pct;
        len  = tracker.fill_level();
        roll = $urandom_range(0, 99);
        case (phase)
            PH_GROW:   insert_pct = 75;
            PH_SHRINK: insert_pct = 20;
            default:   insert_pct = 45;
        endcase
        if (roll >= 95)
            code = ($urandom_range(0, 1) != 0) ? CMD_RSVD_7 : CMD_RSVD_6;
        else if (roll < insert_pct)
            case ($urandom_range(0, 2))
                0:       code = pls_pkg::CMD_INS_FIRST;
                1:       code = pls_pkg::CMD_INS_LAST;
                default: code = pls_pkg::CMD_INS_AT;
            endcase
        else
            case ($urandom_range(0, 2))
                0:       code = pls_pkg::CMD_DEL_FIRST;
                1:       code = pls_pkg::CMD_DEL_LAST;
                default: code = pls_pkg::CMD_DEL_AT;
            endcase

        if ($urandom_range(0, 9) < 3)
            pos = pls_pkg::POS_W'($urandom_range(0, 31));
        else if (code == pls_pkg::CMD_INS_AT)
            pos = pls_pkg::POS_W'($urandom_range(1, len + 1));
        else
            pos = pls_pkg::POS_W'($urandom_range(1, (len > 0) ? len : 1));

        if ($urandom_range(0, 9) == 0)
            case ($urandom_range(0, 3))
                0:       value = 32'sh8000_0000;
                1:       value = 32'sh7FFF_FFFF;
                2:       value = '0;
                default: value = pls_pkg::NONE_VALUE;
            endcase
        else
            value = $urandom;
    endtask

    // ------------------------------------------------------------------------
    // Result side. It stalls at random, with calm stretches, and once holds
    // off for a long spell. The sender keeps offering items during the hold,
    // so the block backs up into its command port.
    // ------------------------------------------------------------------------
    initial
    begin
        int  gap;
        int  results_seen;
        bit  long_hold_done;
        bit  rsp_idle_on;
        results_seen   = 0;
        long_hold_done = 1'b0;
        rsp_idle_on    = 1'b1;
        rsp_ch.ready   = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= 300)
            begin
                gap            = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else
                gap = rsp_idle_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            tracker.check_result(rsp_ch.removed_value, rsp_ch.status, rsp_ch.length);
            results_seen++;
            // Switch between stalling and full-speed draining now and then.
            if (results_seen % 150 == 0)
                rsp_idle_on = ($urandom_range(0, 2) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed cases, randomized phases, then drain.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [pls_pkg::CMD_W-1:0]         code;
        logic [pls_pkg::POS_W-1:0]         pos;
        logic signed [pls_pkg::DATA_W-1:0] value;
        phase_t                            phase;
        int                                real_items;
        bit                                paused_once;

        req_ch.valid     = 1'b0;
        req_ch.cmd       = pls_pkg::CMD_INS_FIRST;
        req_ch.position  = '0;
        req_ch.new_value = '0;
        real_items       = 0;
        paused_once      = 1'b0;
        phase            = PH_GROW;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every kind of delete on an empty list reports empty.
        issue_command(pls_pkg::CMD_DEL_FIRST, 5'd0, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_LAST, 5'd0, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_AT, 5'd1, 32'sd0);
        // Inserting at a position on an empty list only accepts position 1.
        issue_command(pls_pkg::CMD_INS_AT, 5'd0, 32'sd5);
        issue_command(pls_pkg::CMD_INS_AT, 5'd2, 32'sd5);
        issue_command(pls_pkg::CMD_INS_AT, 5'd1, 32'sh8000_0000);
        issue_command(pls_pkg::CMD_INS_FIRST, 5'd31, 32'sh7FFF_FFFF);
        issue_command(pls_pkg::CMD_INS_LAST, 5'd0, 32'sd0);
        // Position length+1 appends, and anything past it is out of range.
        issue_command(pls_pkg::CMD_INS_AT, 5'd4, pls_pkg::NONE_VALUE);
        issue_command(pls_pkg::CMD_INS_AT, 5'd31, 32'sd9);
        issue_command(pls_pkg::CMD_INS_AT, 5'd6, 32'sd9);
        // Positional delete rejects 0 and anything beyond the length.
        issue_command(pls_pkg::CMD_DEL_AT, 5'd0, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_AT, 5'd5, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_AT, 5'd31, 32'sd0);
        // The spare codes leave the list alone.
        issue_command(CMD_RSVD_6, 5'd3, 32'sd1);
        issue_command(CMD_RSVD_7, 5'd31, pls_pkg::NONE_VALUE);
        // Take out a middle entry, then the last one, then drain to empty.
        issue_command(pls_pkg::CMD_DEL_AT, 5'd2, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_AT, 5'd3, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_FIRST, 5'd0, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_LAST, 5'd0, 32'sd0);
        issue_command(pls_pkg::CMD_DEL_AT, 5'd1, 32'sd0);

        // The random part runs in phases. The grow phases push the list
        // against full, and the shrink phases drain it back to empty.
        // The spare codes do not count toward the item total.
        while (real_items < RANDOM_ITEMS)
        begin
            if (real_items % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       phase = PH_GROW;
                    1:       phase = PH_SHRINK;
                    default: phase = PH_CHURN;
                endcase
                send_idle_on = ($urandom_range(0, 3) != 0);
            end
            // Once, halfway through, stop and let every result come back.
            if (!paused_once && real_items == RANDOM_ITEMS / 2)
            begin
                paused_once  = 1'b1;
                req_ch.valid <= 1'b0;
                while (tracker.pending_count() != 0)
                    @(posedge clk);
            end
            draw_command(phase, code, pos, value);
            issue_command(code, pos, value);
            if (code != CMD_RSVD_6 && code != CMD_RSVD_7)
                real_items++;
        end
        req_ch.valid <= 1'b0;

        while (tracker.pending_count() != 0)
            @(posedge clk);
        // Any stray result item would show up within this window.
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.flag_leftovers();

        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pls_pkg.sv
rtl/pls_req_if.sv
rtl/pls_rsp_if.sv
rtl/pls_ram.sv
rtl/positional_list_store_core.sv
tb/tb_positional_list_store_core.sv
